// File: rtl/core/ppas_pkg.sv
// shared constants, types and microcode table for the per-cpu page allocator
// used by ppas_seq, ppas_datapath and the top level; no dependencies
`default_nettype none

package ppas_pkg;

   localparam int NUM_CPUS    = 8;
   localparam int NUM_PAGES   = 32768;
   localparam int STEAL_LINKS = 10;
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 32;
   localparam int CPU_W       = 3;
   localparam int IDX_W       = 16;
   localparam int CPU_AW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SCAN_W      = $clog2(NUM_CPUS + 1);
   localparam int CNT_W       = $clog2(STEAL_LINKS + 1);
   localparam int LINK_AW     = $clog2(NUM_PAGES);
   localparam int PFN_W       = ADDR_W - PAGE_SHIFT;
   localparam int STEP_W      = 4;

   localparam logic [IDX_W-1:0]  NIL        = {IDX_W{1'b1}};
   localparam logic [ADDR_W-1:0] LOW_RESET  = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] HIGH_RESET = 32'h8800_0000;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OOM     = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   typedef logic [STEP_W-1:0] step_type;

   // microcode step addresses
   localparam step_type S_IDLE     = 4'd0;
   localparam step_type S_DISPATCH = 4'd1;
   localparam step_type S_CPU_CHK  = 4'd2;
   localparam step_type S_OWN_CHK  = 4'd3;
   localparam step_type S_SCAN     = 4'd4;
   localparam step_type S_SCAN_END = 4'd5;
   localparam step_type S_STEAL    = 4'd6;
   localparam step_type S_WALK     = 4'd7;
   localparam step_type S_CUT      = 4'd8;
   localparam step_type S_POP_RD   = 4'd9;
   localparam step_type S_POP_WB   = 4'd10;
   localparam step_type S_FREE_CHK = 4'd11;
   localparam step_type S_FREE_WB  = 4'd12;
   localparam step_type S_OOM      = 4'd13;
   localparam step_type S_DONE     = 4'd14;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_SCAN_CLR,
      OP_SCAN_NEXT,
      OP_STEAL_INIT,
      OP_WALK,
      OP_CUT,
      OP_POP_RD,
      OP_POP_WB,
      OP_FREE_CHK,
      OP_FREE_WB,
      OP_OOM
   } op_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_START,
      C_IS_FREE,
      C_CPU_BAD,
      C_OWN_HIT,
      C_SCAN_HIT,
      C_SCAN_END,
      C_WALK_STOP,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_t;
      step_type jump_f;
      logic     idle;
      logic     done;
   } ctl_word_type;

   typedef struct packed {
      logic is_free;
      logic cpu_bad;
      logic own_hit;
      logic scan_hit;
      logic scan_end;
      logic walk_stop;
   } dp_flags_type;

   function automatic ctl_word_type uword(op_type op, cond_type cond, step_type jump_t,
                                          step_type jump_f, logic idle, logic done);
      ctl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.jump_t = jump_t;
      w.jump_f = jump_f;
      w.idle   = idle;
      w.done   = done;
      return w;
   endfunction

   // control store: one word per step
   function automatic ctl_word_type ucode_rom(step_type step);
      ctl_word_type w;
      unique case (step)
         S_IDLE:     w = uword(OP_NOP, C_START, S_DISPATCH, S_IDLE, 1'b1, 1'b0);
         S_DISPATCH: w = uword(OP_NOP, C_IS_FREE, S_FREE_CHK, S_CPU_CHK, 1'b0, 1'b0);
         S_CPU_CHK:  w = uword(OP_NOP, C_CPU_BAD, S_OOM, S_OWN_CHK, 1'b0, 1'b0);
         S_OWN_CHK:  w = uword(OP_SCAN_CLR, C_OWN_HIT, S_POP_RD, S_SCAN, 1'b0, 1'b0);
         S_SCAN:     w = uword(OP_SCAN_NEXT, C_SCAN_HIT, S_STEAL, S_SCAN_END, 1'b0, 1'b0);
         S_SCAN_END: w = uword(OP_NOP, C_SCAN_END, S_OOM, S_SCAN, 1'b0, 1'b0);
         S_STEAL:    w = uword(OP_STEAL_INIT, C_ALWAYS, S_WALK, S_WALK, 1'b0, 1'b0);
         S_WALK:     w = uword(OP_WALK, C_WALK_STOP, S_CUT, S_WALK, 1'b0, 1'b0);
         S_CUT:      w = uword(OP_CUT, C_ALWAYS, S_POP_RD, S_POP_RD, 1'b0, 1'b0);
         S_POP_RD:   w = uword(OP_POP_RD, C_ALWAYS, S_POP_WB, S_POP_WB, 1'b0, 1'b0);
         S_POP_WB:   w = uword(OP_POP_WB, C_ALWAYS, S_DONE, S_DONE, 1'b0, 1'b0);
         S_FREE_CHK: w = uword(OP_FREE_CHK, C_ALWAYS, S_FREE_WB, S_FREE_WB, 1'b0, 1'b0);
         S_FREE_WB:  w = uword(OP_FREE_WB, C_ALWAYS, S_DONE, S_DONE, 1'b0, 1'b0);
         S_OOM:      w = uword(OP_OOM, C_ALWAYS, S_DONE, S_DONE, 1'b0, 1'b0);
         S_DONE:     w = uword(OP_NOP, C_OUT_FREE, S_IDLE, S_DONE, 1'b0, 1'b1);
         default:    w = uword(OP_NOP, C_ALWAYS, S_IDLE, S_IDLE, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ppas_seq.sv
// microcode sequencer: step counter, control store lookup, conditional jumps
// depends on ppas_pkg
`default_nettype none

module ppas_seq
   import ppas_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dp_flags_type dp_flags,
   input  wire logic         start,
   input  wire logic         out_free,
   output ctl_word_type      ctl
);

   step_type step_ff;
   step_type step_in;
   logic     cond_hit;

   assign ctl = ucode_rom(step_ff);

   always_comb begin
      unique case (ctl.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_START:     cond_hit = start;
         C_IS_FREE:   cond_hit = dp_flags.is_free;
         C_CPU_BAD:   cond_hit = dp_flags.cpu_bad;
         C_OWN_HIT:   cond_hit = dp_flags.own_hit;
         C_SCAN_HIT:  cond_hit = dp_flags.scan_hit;
         C_SCAN_END:  cond_hit = dp_flags.scan_end;
         C_WALK_STOP: cond_hit = dp_flags.walk_stop;
         C_OUT_FREE:  cond_hit = out_free;
         default:     cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? ctl.jump_t : ctl.jump_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ppas_datapath.sv
// allocator datapath: list heads, next-link table, scan and walk registers
// depends on ppas_pkg; driven one operation per cycle by ppas_seq
`default_nettype none

module ppas_datapath
   import ppas_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire op_type            op,
   input  wire logic              req_load,
   input  wire logic              req_cmd,
   input  wire logic [CPU_W-1:0]  req_cpu,
   input  wire logic [ADDR_W-1:0] req_addr,
   input  wire logic [ADDR_W-1:0] low_bound,
   input  wire logic [ADDR_W-1:0] high_bound,
   output dp_flags_type           dp_flags,
   output logic [1:0]             res_status,
   output logic [ADDR_W-1:0]      res_page_addr
);

   logic [IDX_W-1:0]  head_ff [NUM_CPUS];
   logic [IDX_W-1:0]  head_in [NUM_CPUS];
   logic [SCAN_W-1:0] v_ff, v_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              cmd_ff, cmd_in;
   logic [CPU_W-1:0]  cpu_ff, cpu_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W:0]   base_ff, base_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic              ok_ff, ok_in;
   logic [ADDR_W-1:0] diff_ff, diff_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;

   logic [IDX_W-1:0]  link_mem [NUM_PAGES];
   logic [IDX_W-1:0]  rd_ff;
   logic              rd_nil_ff;
   logic [IDX_W-1:0]  raddr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  mem_wdata;

   logic [CPU_AW-1:0] cpu_idx, v_idx;
   logic [IDX_W-1:0]  lnk;
   logic              cpu_bad, scan_hit, walk_stop, free_ok;

   assign cpu_idx   = cpu_ff[CPU_AW-1:0];
   assign v_idx     = v_ff[CPU_AW-1:0];
   // link read beyond the table counts as end of list
   assign lnk       = rd_nil_ff ? NIL : rd_ff;
   assign cpu_bad   = SCAN_W'(cpu_ff) >= SCAN_W'(NUM_CPUS);
   assign scan_hit  = (v_ff < SCAN_W'(NUM_CPUS)) && (v_ff != SCAN_W'(cpu_ff)) &&
                      (head_ff[v_idx] != NIL);
   assign walk_stop = (lnk == NIL) || (cnt_ff == CNT_W'(STEAL_LINKS));
   assign free_ok   = ok_ff && (diff_ff[ADDR_W-1:PAGE_SHIFT] < PFN_W'(NUM_PAGES));

   assign dp_flags.is_free   = cmd_ff;
   assign dp_flags.cpu_bad   = cpu_bad;
   assign dp_flags.own_hit   = !cpu_bad && (head_ff[cpu_idx] != NIL);
   assign dp_flags.scan_hit  = scan_hit;
   assign dp_flags.scan_end  = v_ff == SCAN_W'(NUM_CPUS);
   assign dp_flags.walk_stop = walk_stop;

   assign res_status    = res_status_ff;
   assign res_page_addr = res_addr_ff;

   always_comb begin
      head_in       = head_ff;
      v_in          = v_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      cpu_in        = cpu_ff;
      addr_in       = addr_ff;
      ptr_in        = ptr_ff;
      first_in      = first_ff;
      ok_in         = ok_ff;
      diff_in       = diff_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      raddr         = ptr_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = NIL;
      // page base: low bound rounded up to a page boundary
      base_in = ({1'b0, low_bound} + (ADDR_W+1)'((1 << PAGE_SHIFT) - 1)) &
                ~(ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

      if (req_load) begin
         cmd_in  = req_cmd;
         cpu_in  = req_cpu;
         addr_in = req_addr;
      end

      case (op)
         OP_SCAN_CLR: begin
            v_in = '0;
         end
         OP_SCAN_NEXT: begin
            if (!scan_hit) begin
               v_in = v_ff + SCAN_W'(1);
            end
         end
         OP_STEAL_INIT: begin
            first_in = head_ff[v_idx];
            ptr_in   = head_ff[v_idx];
            cnt_in   = '0;
            raddr    = head_ff[v_idx];
         end
         OP_WALK: begin
            if (!walk_stop) begin
               ptr_in = lnk;
               cnt_in = cnt_ff + CNT_W'(1);
               raddr  = lnk;
            end
         end
         OP_CUT: begin
            head_in[v_idx]   = lnk;
            head_in[cpu_idx] = first_ff;
            if (ptr_ff < IDX_W'(NUM_PAGES)) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = NIL;
            end
         end
         OP_POP_RD: begin
            ptr_in = head_ff[cpu_idx];
            raddr  = head_ff[cpu_idx];
         end
         OP_POP_WB: begin
            head_in[cpu_idx] = lnk;
            res_status_in    = ST_OK;
            res_addr_in      = base_ff[ADDR_W-1:0] + (ADDR_W'(ptr_ff) << PAGE_SHIFT);
         end
         OP_FREE_CHK: begin
            ok_in   = !cpu_bad && (addr_ff[PAGE_SHIFT-1:0] == '0) &&
                      (addr_ff >= low_bound) && (addr_ff < high_bound) &&
                      ({1'b0, addr_ff} >= base_ff);
            diff_in = addr_ff - base_ff[ADDR_W-1:0];
         end
         OP_FREE_WB: begin
            res_addr_in = '0;
            if (free_ok) begin
               mem_we           = 1'b1;
               mem_waddr        = diff_ff[PAGE_SHIFT +: IDX_W];
               mem_wdata        = head_ff[cpu_idx];
               head_in[cpu_idx] = diff_ff[PAGE_SHIFT +: IDX_W];
               res_status_in    = ST_OK;
            end else begin
               res_status_in = ST_BADFREE;
            end
         end
         OP_OOM: begin
            res_status_in = ST_OOM;
            res_addr_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            head_ff[i] <= NIL;
         end
         v_ff   <= '0;
         cnt_ff <= '0;
      end else begin
         head_ff <= head_in;
         v_ff    <= v_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cpu_ff        <= cpu_in;
      addr_ff       <= addr_in;
      base_ff       <= base_in;
      ptr_ff        <= ptr_in;
      first_ff      <= first_in;
      ok_ff         <= ok_in;
      diff_ff       <= diff_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
   end

   // next-link table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr[LINK_AW-1:0]] <= mem_wdata;
      end
      rd_ff     <= link_mem[raddr[LINK_AW-1:0]];
      rd_nil_ff <= raddr >= IDX_W'(NUM_PAGES);
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      op == OP_POP_RD |-> head_ff[cpu_idx] != NIL)
      else $error("pop issued on an empty list");

   a_cut_fills_own: assert property (@(posedge clock) disable iff (reset)
      op == OP_CUT |=> head_ff[$past(cpu_idx)] != NIL)
      else $error("stolen run left requester list empty");

endmodule

`default_nettype wire

// File: rtl/core/per_cpu_page_allocator_steal.sv
// top level of the per-cpu page allocator with stealing
// depends on ppas_pkg, ppas_seq and ppas_datapath
`default_nettype none

// Manages 4096-byte pages on one LIFO free list per CPU, chained through a
// 32768-entry next-link table. A free beat checks the CPU number, alignment,
// the low/high bounds and the table size, then pushes the page on that CPU's
// list (status 2 on a bad address). An allocate beat pops the CPU's own list;
// if it is empty the other CPUs are scanned in ascending order and up to 11
// pages are moved from the first non-empty one before the pop (status 1,
// address 0 when every list is empty or the CPU number is bad). Work is done
// by a microcoded sequencer, one beat at a time. A finished result waits in
// an output register, so the next request is taken while it is held by
// rsp_stall. After reset all lists are empty and software frees pages in;
// the link table needs no clearing pass. The bound registers lie at byte 0
// (low bound) and 4 (high bound); the user must write them only while idle,
// and the block itself does not enforce it.

module per_cpu_page_allocator_steal
   import ppas_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [CPU_W-1:0]  req_cpu,
   input  wire logic [ADDR_W-1:0] req_addr,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [ADDR_W-1:0]      rsp_page_addr,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   // register index from paddr[2]
   localparam logic REG_LOW_BOUND  = 1'b0;
   localparam logic REG_HIGH_BOUND = 1'b1;

   logic [ADDR_W-1:0] low_bound_ff, low_bound_in;
   logic [ADDR_W-1:0] high_bound_ff, high_bound_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   ctl_word_type ctl;
   dp_flags_type dp_flags;
   logic         req_accept;
   logic         out_free;
   logic         out_load;
   logic         csr_write;
   logic [1:0]   res_status;
   logic [ADDR_W-1:0] res_page_addr;

   // requests are taken only while the sequencer sits at its idle step
   assign req_stall  = !ctl.idle;
   assign req_accept = req_valid && ctl.idle;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = ctl.done && out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_page_addr = rsp_addr_ff;

   ppas_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .dp_flags (dp_flags),
      .start    (req_valid),
      .out_free (out_free),
      .ctl      (ctl)
   );

   ppas_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .op            (ctl.op),
      .req_load      (req_accept),
      .req_cmd       (req_cmd),
      .req_cpu       (req_cpu),
      .req_addr      (req_addr),
      .low_bound     (low_bound_ff),
      .high_bound    (high_bound_ff),
      .dp_flags      (dp_flags),
      .res_status    (res_status),
      .res_page_addr (res_page_addr)
   );

   // register port: pready is tied high, so transfers never wait
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      low_bound_in  = low_bound_ff;
      high_bound_in = high_bound_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_LOW_BOUND:  low_bound_in  = pwdata;
            REG_HIGH_BOUND: high_bound_in = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_LOW_BOUND:  prdata = low_bound_ff;
         REG_HIGH_BOUND: prdata = high_bound_ff;
         default:        prdata = '0;
      endcase
   end

   // result beat holding register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_addr_in   = res_page_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= LOW_RESET;
         high_bound_ff <= HIGH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // an accepted request always leaves the idle step
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !ctl.idle)
      else $error("sequencer stayed idle after accepting a request");

   // a finished result always lands in the output register
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("finished result not presented");

   // failures never carry an address; frees also return address 0, but only failures are checked here
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_page_addr == '0)
      else $error("failed result carries a page address");

endmodule

`default_nettype wire
